// ----- design/wsicon_pkg.sv -----
// Shared constants and helper functions for the signal status icon pixel generator.
// Depends on nothing; imported by the generator and its port checker.
`default_nettype none

package wsicon_pkg;

    // Icon geometry and port widths
    localparam int ICON_SIDE   = 34;
    localparam int PIX_W       = 6;
    localparam int COLOR_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 8;

    // Signed offset from the centre, squared offset and squared distance
    localparam int OFS_W       = PIX_W + 1;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int D2_W        = SQ_W + 1;

    // Colours
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 16'hF800;
    localparam logic [COLOR_W-1:0] BG_RESET    = 16'hFFFF;

    // Disc and bands
    localparam int HUB_X       = 18;
    localparam int HUB_Y       = 17;
    localparam int DOT_R       = 2;
    localparam int NUM_BANDS   = 3;
    localparam int FIRST_RING  = 7;
    localparam int RING_STEP   = 4;
    localparam int RING_WIDTH  = 2;

    // Diagonal slash of 3x3 squares
    localparam int SLASH_X0    = 27;
    localparam int SLASH_Y0    = 3;
    localparam int SLASH_STEPS = 16;
    localparam int SLASH_HALF  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHOWN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG    = 2'd3;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [PIX_W-1:0]   t_pix;

    // Outer radius of band k
    function automatic int band_outer(input int k);
        return FIRST_RING + k * RING_STEP;
    endfunction

    // Inner radius of band k
    function automatic int band_inner(input int k);
        return band_outer(k) - RING_WIDTH;
    endfunction

endpackage

`default_nettype wire

// ----- design/wifi_status_icon_pixel_generator.sv -----
// Pixel generator for the signal status icon: three-stage colour pipeline.
// Depends on wsicon_pkg for geometry, colours and register indexes.
`default_nettype none

// Usage
//   Input: a pixel coordinate on i_pixel_x / i_pixel_y, transferred at a rising
//   edge with start high and busy low. busy is always low, so one pixel can be
//   started in every cycle.
//   Output: o_valid strobes for one cycle with o_pixel_color and o_icon_hidden.
//   The receiver cannot hold results off; every result shows exactly once.
//   A pixel's result passes through three register stages (coordinate offsets
//   and slash test, squares and sector test, distance sum with band compares
//   and colour select) on its way to the outputs. Throughput: one pixel per
//   clock.
//   Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
//   (shown, level, alert, background) at the same edge, with no wait. Write
//   only while no pixel is in flight.
//   Reset: synchronous, active low. It empties the pipeline and sets shown,
//   level and alert to 0 and the background to white.
//   A hidden icon gives o_icon_hidden high and colour 0.
module wifi_status_icon_pixel_generator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [wsicon_pkg::PIX_W-1:0]         i_pixel_x,
    input  wire logic [wsicon_pkg::PIX_W-1:0]         i_pixel_y,
    input  wire logic                                 i_cfg_we,
    input  wire logic [wsicon_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [wsicon_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                      o_valid,
    output logic [wsicon_pkg::COLOR_W-1:0]            o_pixel_color,
    output logic                                      o_icon_hidden
);
    import wsicon_pkg::*;

    // Configuration registers
    logic                r_shown;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_alert;
    t_color              r_bg;

    // Stage 1: offsets from the centre, icon bounds, slash hit
    logic                     r_v1;
    logic signed [OFS_W-1:0]  r_ex1;
    logic signed [OFS_W-1:0]  r_ey1;
    logic                     r_in1;
    logic                     r_red1;
    logic signed [OFS_W-1:0]  n_ex1;
    logic signed [OFS_W-1:0]  n_ey1;
    logic                     n_in1;
    logic                     n_red1;

    // Stage 2: squares, upward sector, apex helpers
    logic                     r_v2;
    logic [SQ_W-1:0]          r_exsq2;
    logic [SQ_W-1:0]          r_eysq2;
    logic                     r_sect2;
    logic                     r_ex0_2;
    logic signed [OFS_W-1:0]  r_ey2;
    logic                     r_in2;
    logic                     r_red2;
    logic [OFS_W-1:0]         n_abs_ex;
    logic                     n_sect2;

    // Stage 3: distance, bands, colour
    logic [D2_W-1:0]          n_d2;
    logic [1:0]               n_bands;
    logic                     n_black;
    t_color                   n_color;
    logic                     r_valid;
    t_color                   r_color;
    logic                     r_hidden;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= 1'b0;
            r_level <= '0;
            r_alert <= 1'b0;
            r_bg    <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHOWN: r_shown <= i_cfg_data[0];
                REG_LEVEL: r_level <= i_cfg_data[LEVEL_W-1:0];
                REG_ALERT: r_alert <= i_cfg_data[0];
                REG_BG:    r_bg    <= i_cfg_data[COLOR_W-1:0];
            endcase
        end
    end

    // Stage 1 logic: offsets, bounds and slash squares
    always_comb begin
        logic [OFS_W-1:0] xk;
        logic [OFS_W-1:0] yu;
        n_ex1  = OFS_W'($signed({1'b0, i_pixel_x})) - OFS_W'(HUB_X);
        n_ey1  = OFS_W'(HUB_Y) - OFS_W'($signed({1'b0, i_pixel_y}));
        n_in1  = ({1'b0, i_pixel_x} < OFS_W'(ICON_SIDE))
              && ({1'b0, i_pixel_y} < OFS_W'(ICON_SIDE));
        n_red1 = 1'b0;
        yu     = {1'b0, i_pixel_y};
        // Square k is centred at (SLASH_X0-k, SLASH_Y0+k)
        for (int k = 0; k < SLASH_STEPS; k++) begin
            xk = {1'b0, i_pixel_x} + OFS_W'(k);
            if (xk >= OFS_W'(SLASH_X0 - SLASH_HALF) && xk <= OFS_W'(SLASH_X0 + SLASH_HALF)
                && yu >= OFS_W'(SLASH_Y0 + k - SLASH_HALF)
                && yu <= OFS_W'(SLASH_Y0 + k + SLASH_HALF)) begin
                n_red1 = 1'b1;
            end
        end
    end

    // Stage 2 logic: upward 90-degree sector
    always_comb begin
        n_abs_ex = (r_ex1 < 0) ? OFS_W'(-r_ex1) : OFS_W'(r_ex1);
        n_sect2  = (r_ey1 >= 0) && ($signed(n_abs_ex) <= r_ey1);
    end

    // Stage 3 logic: disc, bands less their apex, slash overwrite, hidden override
    always_comb begin
        n_d2    = D2_W'(r_exsq2) + D2_W'(r_eysq2);
        n_bands = (r_level == '0 || r_level > LEVEL_W'(NUM_BANDS))
                ? 2'(NUM_BANDS) : r_level[1:0];
        n_black = (n_d2 <= D2_W'(DOT_R * DOT_R));
        for (int k = 0; k < NUM_BANDS; k++) begin
            if (r_sect2 && (2'(k) < n_bands)
                && n_d2 >= D2_W'(band_inner(k) * band_inner(k))
                && n_d2 <= D2_W'(band_outer(k) * band_outer(k))
                && !(r_ex0_2 && r_ey2 == OFS_W'(band_outer(k)))) begin
                n_black = 1'b1;
            end
        end
        n_color = r_bg;
        if (r_in2) begin
            if (n_black) begin
                n_color = COLOR_BLACK;
            end
            if (r_alert && r_red2) begin
                n_color = COLOR_RED;
            end
        end
        if (!r_shown) begin
            n_color = COLOR_BLACK;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= start && !busy;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_ex1    <= n_ex1;
        r_ey1    <= n_ey1;
        r_in1    <= n_in1;
        r_red1   <= n_red1;
        r_exsq2  <= SQ_W'(r_ex1 * r_ex1);
        r_eysq2  <= SQ_W'(r_ey1 * r_ey1);
        r_sect2  <= n_sect2;
        r_ex0_2  <= (r_ex1 == '0);
        r_ey2    <= r_ey1;
        r_in2    <= r_in1;
        r_red2   <= r_red1;
        r_color  <= n_color;
        r_hidden <= !r_shown;
    end

    assign busy          = 1'b0;
    assign o_valid       = r_valid;
    assign o_pixel_color = r_color;
    assign o_icon_hidden = r_hidden;

endmodule

`default_nettype wire

// ----- design/wsicon_checker.sv -----
// Port-level checker for the signal status icon pixel generator, with its bind.
// Depends on wsicon_pkg for widths and colours.
`default_nettype none

module wsicon_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic                                 o_valid,
    input  wire logic [wsicon_pkg::COLOR_W-1:0]       o_pixel_color,
    input  wire logic                                 o_icon_hidden
);
    import wsicon_pkg::*;

    // Every transfer yields a result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three cycles after transfer");

    // No result without a transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##3 !o_valid)
        else $error("result without a matching transfer");

    // A hidden icon gives colour zero
    a_hidden_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_icon_hidden) |-> (o_pixel_color == COLOR_BLACK))
        else $error("hidden icon with non-zero colour");

    // The pipeline never refuses a pixel
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind wifi_status_icon_pixel_generator wsicon_checker u_wsicon_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_pixel_color (o_pixel_color),
    .o_icon_hidden (o_icon_hidden)
);

`default_nettype wire

// ----- dv/tb_wifi_status_icon_pixel_generator.sv -----
// Self-checking testbench for the signal status icon pixel generator.
// Depends on wsicon_pkg and wifi_status_icon_pixel_generator; colours are predicted
// from shadow copies of the four configuration registers.
`timescale 1ns / 1ps

module tb_wifi_status_icon_pixel_generator;
    import wsicon_pkg::*;

    localparam int RANDOM_PIXELS  = 1350;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIRECTED_ROWS  = 27;

    typedef struct packed {
        t_color color;
        logic   hidden;
    } t_pixel_out;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        t_pix                    x;
        t_pix                    y;
        logic                    typed;
        t_pixel_out              want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_pix                   i_pixel_x;
    t_pix                   i_pixel_y;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_valid;
    t_color                 o_pixel_color;
    logic                   o_icon_hidden;

    // Shadow copies of the configuration registers
    logic                   shown_r;
    logic [LEVEL_W-1:0]     level_r;
    logic                   alert_r;
    t_color                 bg_r;

    t_pixel_out             colours_due [$];
    t_pixel_out             oldest;
    int                     mismatches;
    int                     idle_cycles;

    // Directed stimulus: hidden icon, disc, band apexes and edges, pixels outside
    // the icon, level clamping, slash over black, and a hide at the end
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_PIXEL, '0, '0, 6'd0,  6'd0,  1'b1, '{16'h0000, 1'b1}},
        '{ROW_PIXEL, '0, '0, 6'd63, 6'd63, 1'b1, '{16'h0000, 1'b1}},
        '{ROW_WRITE, REG_SHOWN, 16'hFFFF, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd17, 1'b1, '{16'h0000, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd10, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd11, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd6,  1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd2,  1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd3,  1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd0,  6'd0,  1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd63, 6'd0,  1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd33, 6'd34, 1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_WRITE, REG_LEVEL, 16'hFF01, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd6,  1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd12, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd22, 6'd12, 1'b0, '0},
        '{ROW_WRITE, REG_LEVEL, 16'h00FF, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd18, 6'd6,  1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd24, 6'd11, 1'b0, '0},
        '{ROW_WRITE, REG_ALERT, 16'hFFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_BG,    16'h0000, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd27, 6'd3,  1'b1, '{16'hF800, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd12, 6'd18, 1'b1, '{16'hF800, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd33, 6'd33, 1'b1, '{16'h0000, 1'b0}},
        '{ROW_PIXEL, '0, '0, 6'd19, 6'd11, 1'b0, '0},
        '{ROW_WRITE, REG_SHOWN, 16'hFFFE, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 6'd33, 6'd0,  1'b1, '{16'h0000, 1'b1}}
    };

    logic [CFG_IDX_W-1:0] reg_order [4] = '{REG_SHOWN, REG_LEVEL, REG_ALERT, REG_BG};

    wifi_status_icon_pixel_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color),
        .o_icon_hidden (o_icon_hidden)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Colour of one pixel under the current register settings
    function automatic t_pixel_out shade_pixel(input t_pix px, input t_pix py);
        t_pixel_out res;
        int         ex;
        int         ey;
        int         d2;
        int         bands;
        int         r_out;
        int         r_in;
        int         dx;
        int         dy;
        logic       black;
        logic       red;
        res.color = bg_r;
        res.hidden = 1'b0;
        black = 1'b0;
        red = 1'b0;
        if (!shown_r) begin
            res.color = '0;
            res.hidden = 1'b1;
            return res;
        end
        // out-of-range levels fall back to the full set of bands
        bands = (level_r == 0 || level_r > NUM_BANDS) ? NUM_BANDS : int'(level_r);
        if (px < ICON_SIDE && py < ICON_SIDE) begin
            ex = int'(px) - HUB_X;
            ey = HUB_Y - int'(py);
            d2 = ex * ex + ey * ey;
            if (d2 <= DOT_R * DOT_R) begin
                black = 1'b1;
            end else if (ey >= 0 && (ex < 0 ? -ex : ex) <= ey) begin
                // upward sector bands, each without its apex pixel
                for (int k = 0; k < bands; k++) begin
                    r_out = FIRST_RING + k * RING_STEP;
                    r_in = r_out - RING_WIDTH;
                    if (d2 >= r_in * r_in && d2 <= r_out * r_out && !(ex == 0 && ey == r_out))
                        black = 1'b1;
                end
            end
            for (int k = 0; k < SLASH_STEPS; k++) begin
                dx = int'(px) - (SLASH_X0 - k);
                dy = int'(py) - (SLASH_Y0 + k);
                if ((dx < 0 ? -dx : dx) <= SLASH_HALF && (dy < 0 ? -dy : dy) <= SLASH_HALF)
                    red = 1'b1;
            end
            if (black)
                res.color = COLOR_BLACK;
            if (alert_r && red)
                res.color = COLOR_RED;
        end
        return res;
    endfunction

    // Mostly inside the icon, sometimes anywhere the port allows
    function automatic t_pix rand_coord();
        if ($urandom_range(0, 4) == 0)
            return t_pix'($urandom_range(0, 63));
        return t_pix'($urandom_range(0, ICON_SIDE - 1));
    endfunction

    // Random value for one register, upper data bits filled with noise
    function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        case (idx)
            REG_SHOWN: return {noise[15:1], 1'($urandom_range(0, 9) != 0)};
            REG_LEVEL: begin
                case ($urandom_range(0, 6))
                    0:       return {noise[15:8], 8'd0};
                    1:       return {noise[15:8], 8'd1};
                    2:       return {noise[15:8], 8'd2};
                    3:       return {noise[15:8], 8'd3};
                    4:       return {noise[15:8], 8'd255};
                    5:       return {noise[15:8], 8'd4};
                    default: return {noise[15:8], 8'($urandom_range(4, 255))};
                endcase
            end
            REG_ALERT: return noise;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    default: return noise;
                endcase
            end
        endcase
    endfunction

    // Hold off new pixels until every expected colour has come back
    task automatic drain_pipeline();
        if (colours_due.size() != 0) begin
            start <= 1'b0;
            while (colours_due.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // Present one pixel, wait for its transfer and log the colour it should give
    task automatic send_pixel(input t_pix px, input t_pix py, input t_pixel_out want);
        i_cfg_we <= 1'b0;
        start <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        colours_due.push_back(want);
    endtask

    // Register write on an idle block; the shadow follows at the same edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SHOWN: shown_r = data[0];
            REG_LEVEL: level_r = data[LEVEL_W-1:0];
            REG_ALERT: alert_r = data[0];
            default:   bg_r = data;
        endcase
    endtask

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Check each result against the oldest expectation; count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (colours_due.size() == 0) begin
                $error("unexpected result: pixel_color %h icon_hidden %b",
                       o_pixel_color, o_icon_hidden);
                mismatches++;
            end else begin
                oldest = colours_due.pop_front();
                if (o_pixel_color !== oldest.color) begin
                    $error("pixel_color: expected %h, actual %h", oldest.color, o_pixel_color);
                    mismatches++;
                end
                if (o_icon_hidden !== oldest.hidden) begin
                    $error("icon_hidden: expected %b, actual %b", oldest.hidden, o_icon_hidden);
                    mismatches++;
                end
            end
        end
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         burst;
        int         phase_len;
        int         in_phase;
        bit         first_phase;
        t_pix       px;
        t_pix       py;
        t_pixel_out want;

        mismatches = 0;
        idle_cycles = 0;
        shown_r = 1'b0;
        level_r = '0;
        alert_r = 1'b0;
        bg_r = BG_RESET;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_pixel_x <= '0;
        i_pixel_y <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                want = directed_rows[r].typed ? directed_rows[r].want
                                              : shade_pixel(directed_rows[r].x, directed_rows[r].y);
                send_pixel(directed_rows[r].x, directed_rows[r].y, want);
            end
        end

        // Random phases: retune some registers, then bursts of pixels with gaps
        sent = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_PIXELS) begin
            foreach (reg_order[i]) begin
                if (first_phase || $urandom_range(0, 1) == 1)
                    write_reg(reg_order[i], rand_reg_value(reg_order[i]));
            end
            first_phase = 1'b0;
            phase_len = $urandom_range(40, 160);
            in_phase = 0;
            while (in_phase < phase_len && sent < RANDOM_PIXELS) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst; b++) begin
                    px = rand_coord();
                    py = rand_coord();
                    send_pixel(px, py, shade_pixel(px, py));
                    sent++;
                    in_phase++;
                end
                if ($urandom_range(0, 2) != 0)
                    rest($urandom_range(1, 12));
                if ($urandom_range(0, 24) == 0)
                    drain_pipeline();
            end
        end

        // Let the pipeline empty, then a short tail for stray strobes
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
